// ===== src/pip_pkg.sv =====
// ============================================================================
// pip_pkg
// Shared constants and types for the point-in-polygon crossing block.
// ============================================================================
package pip_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FAR_RESET      = 10000;
    localparam int FAR_MIN_BITS   = 15;
    localparam int CFG_ADDR_BITS  = 1;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_FAR_X = 1'b0,
        CFG_FAR_Y = 1'b1
    } pip_cfg_addr_t;

    typedef struct packed {
        logic first;
        logic last;
    } pip_flags_t;

endpackage

// ===== src/point_in_polygon_crossing.sv =====
// Throughput: one vertex word per cycle, set by the three-stage pipeline
// (operand register, product register, result register), while the product stage is
// not holding a polygon's last word whose result register still waits for m_ready.
// Input ready stays high while a result waits, as long as the pipeline has room.
// Reset clears the chain state and parity and loads 10000 into both far registers.
// ============================================================================
// point_in_polygon_crossing
// Crossing-parity point-in-polygon test over a stream of vertex words.
// ============================================================================
module point_in_polygon_crossing #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pip_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COORD_BITS-1:0]             cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COORD_BITS-1:0]      s_vertex_x,
    input  logic signed [COORD_BITS-1:0]      s_vertex_y,
    input  logic signed [COORD_BITS-1:0]      s_query_x,
    input  logic signed [COORD_BITS-1:0]      s_query_y,
    input  logic                              s_first_vertex,
    input  logic                              s_last_vertex,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_inside_res
);
    import pip_pkg::*;

    localparam int FAR_BITS = (COORD_BITS > FAR_MIN_BITS) ? COORD_BITS : FAR_MIN_BITS;

    logic signed [COORD_BITS:0] main_dx, main_dy, main_wx, main_wy;
    logic signed [COORD_BITS:0] close_dx, close_dy, close_wx, close_wy;
    logic signed [FAR_BITS:0]   ray_ex, ray_ey;
    pip_flags_t                 flags_in, flags1, flags2_reg;
    logic                       v1_reg, v2_reg, m_valid_reg, inside_reg;
    logic                       ready2, retire, accept, hit_main, hit_close, parity_reg;
    logic                       parity_next;

    assign flags_in.first = s_first_vertex;
    assign flags_in.last  = s_last_vertex;

    assign ready2  = !v2_reg || !flags2_reg.last || !m_valid_reg || m_ready;
    assign s_ready = !v1_reg || ready2;
    assign accept  = s_valid && s_ready;
    assign retire  = v2_reg && ready2;

    pip_front #(
        .COORD_BITS(COORD_BITS),
        .FAR_BITS  (FAR_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .accept     (accept),
        .vertex_x   (s_vertex_x),
        .vertex_y   (s_vertex_y),
        .query_x    (s_query_x),
        .query_y    (s_query_y),
        .flags_in   (flags_in),
        .main_dx    (main_dx),
        .main_dy    (main_dy),
        .main_wx    (main_wx),
        .main_wy    (main_wy),
        .close_dx   (close_dx),
        .close_dy   (close_dy),
        .close_wx   (close_wx),
        .close_wy   (close_wy),
        .ray_ex     (ray_ex),
        .ray_ey     (ray_ey),
        .flags_out  (flags1)
    );

    pip_edge #(
        .COORD_BITS(COORD_BITS),
        .FAR_BITS  (FAR_BITS)
    ) u_edge_main (
        .aclk(aclk),
        .en  (ready2),
        .d_x (main_dx),
        .d_y (main_dy),
        .w_x (main_wx),
        .w_y (main_wy),
        .e_x (ray_ex),
        .e_y (ray_ey),
        .hit (hit_main)
    );

    pip_edge #(
        .COORD_BITS(COORD_BITS),
        .FAR_BITS  (FAR_BITS)
    ) u_edge_close (
        .aclk(aclk),
        .en  (ready2),
        .d_x (close_dx),
        .d_y (close_dy),
        .w_x (close_wx),
        .w_y (close_wy),
        .e_x (ray_ex),
        .e_y (ray_ey),
        .hit (hit_close)
    );

    always_ff @(posedge aclk) begin
        if (ready2) begin
            flags2_reg <= flags1;
        end
    end

    always_comb begin
        parity_next = (flags2_reg.first ? 1'b0 : parity_reg)
                    ^ (!flags2_reg.first && hit_main)
                    ^ (flags2_reg.last && hit_close);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            parity_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (retire) begin
                parity_reg <= parity_next;
            end
            if (retire && flags2_reg.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (retire && flags2_reg.last) begin
            inside_reg <= parity_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = inside_reg;

endmodule

// ===== src/pip_front.sv =====
// ============================================================================
// pip_front
// Far point registers, polygon chain state and the operand stage. On each
// accepted word it forms the edge and ray difference vectors for the chain
// edge and the closing edge.
// ============================================================================
module pip_front #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
    parameter int FAR_BITS   = pip_pkg::FAR_MIN_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pip_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [COORD_BITS-1:0]                cfg_wr_data,
    input  logic                                 accept,
    input  logic signed [COORD_BITS-1:0]         vertex_x,
    input  logic signed [COORD_BITS-1:0]         vertex_y,
    input  logic signed [COORD_BITS-1:0]         query_x,
    input  logic signed [COORD_BITS-1:0]         query_y,
    input  pip_pkg::pip_flags_t                  flags_in,
    output logic signed [COORD_BITS:0]           main_dx,
    output logic signed [COORD_BITS:0]           main_dy,
    output logic signed [COORD_BITS:0]           main_wx,
    output logic signed [COORD_BITS:0]           main_wy,
    output logic signed [COORD_BITS:0]           close_dx,
    output logic signed [COORD_BITS:0]           close_dy,
    output logic signed [COORD_BITS:0]           close_wx,
    output logic signed [COORD_BITS:0]           close_wy,
    output logic signed [FAR_BITS:0]             ray_ex,
    output logic signed [FAR_BITS:0]             ray_ey,
    output pip_pkg::pip_flags_t                  flags_out
);
    import pip_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int EW = FAR_BITS + 1;

    logic signed [FAR_BITS-1:0]   far_x_reg;
    logic signed [FAR_BITS-1:0]   far_y_reg;
    logic signed [COORD_BITS-1:0] start_x_reg, start_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] held_qx_reg, held_qy_reg;

    logic signed [COORD_BITS-1:0] qx_eff, qy_eff, sx_eff, sy_eff;
    logic signed [DW-1:0]         main_dx_reg, main_dy_reg, main_wx_reg, main_wy_reg;
    logic signed [DW-1:0]         close_dx_reg, close_dy_reg, close_wx_reg, close_wy_reg;
    logic signed [EW-1:0]         ray_ex_reg, ray_ey_reg;
    pip_flags_t                   flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            far_x_reg <= FAR_BITS'(FAR_RESET);
            far_y_reg <= FAR_BITS'(FAR_RESET);
        end else if (cfg_wr_en) begin
            unique case (pip_cfg_addr_t'(cfg_addr))
                CFG_FAR_X: far_x_reg <= FAR_BITS'($signed(cfg_wr_data));
                CFG_FAR_Y: far_y_reg <= FAR_BITS'($signed(cfg_wr_data));
                default:   far_x_reg <= far_x_reg;
            endcase
        end
    end

    always_comb begin
        qx_eff = flags_in.first ? query_x  : held_qx_reg;
        qy_eff = flags_in.first ? query_y  : held_qy_reg;
        sx_eff = flags_in.first ? vertex_x : start_x_reg;
        sy_eff = flags_in.first ? vertex_y : start_y_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            held_qx_reg <= '0;
            held_qy_reg <= '0;
        end else if (accept) begin
            start_x_reg <= sx_eff;
            start_y_reg <= sy_eff;
            held_qx_reg <= qx_eff;
            held_qy_reg <= qy_eff;
            prev_x_reg  <= vertex_x;
            prev_y_reg  <= vertex_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            main_dx_reg  <= DW'(vertex_x) - DW'(prev_x_reg);
            main_dy_reg  <= DW'(vertex_y) - DW'(prev_y_reg);
            main_wx_reg  <= DW'(prev_x_reg) - DW'(qx_eff);
            main_wy_reg  <= DW'(prev_y_reg) - DW'(qy_eff);
            close_dx_reg <= DW'(sx_eff) - DW'(vertex_x);
            close_dy_reg <= DW'(sy_eff) - DW'(vertex_y);
            close_wx_reg <= DW'(vertex_x) - DW'(qx_eff);
            close_wy_reg <= DW'(vertex_y) - DW'(qy_eff);
            ray_ex_reg   <= EW'(far_x_reg) - EW'(qx_eff);
            ray_ey_reg   <= EW'(far_y_reg) - EW'(qy_eff);
            flags_reg    <= flags_in;
        end
    end

    assign main_dx   = main_dx_reg;
    assign main_dy   = main_dy_reg;
    assign main_wx   = main_wx_reg;
    assign main_wy   = main_wy_reg;
    assign close_dx  = close_dx_reg;
    assign close_dy  = close_dy_reg;
    assign close_wx  = close_wx_reg;
    assign close_wy  = close_wy_reg;
    assign ray_ex    = ray_ex_reg;
    assign ray_ey    = ray_ey_reg;
    assign flags_out = flags_reg;

endmodule

// ===== src/pip_edge.sv =====
// ============================================================================
// pip_edge
// Exact segment crossing test. Registers the six products of the three cross products, then
// checks both parameters against the determinant without division.
// ============================================================================
module pip_edge #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
    parameter int FAR_BITS   = pip_pkg::FAR_MIN_BITS
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [COORD_BITS:0] d_x,
    input  logic signed [COORD_BITS:0] d_y,
    input  logic signed [COORD_BITS:0] w_x,
    input  logic signed [COORD_BITS:0] w_y,
    input  logic signed [FAR_BITS:0]   e_x,
    input  logic signed [FAR_BITS:0]   e_y,
    output logic                      hit
);
    import pip_pkg::*;

    localparam int PW = COORD_BITS + FAR_BITS + 2;
    localparam int SW = PW + 1;

    logic signed [PW-1:0] dxey_reg, dyex_reg, exwy_reg, eywx_reg, dxwy_reg, dywx_reg;
    logic signed [SW-1:0] det, num1, num2;
    logic                 pos_ok, neg_ok;

    always_ff @(posedge aclk) begin
        if (en) begin
            dxey_reg <= d_x * e_y;
            dyex_reg <= d_y * e_x;
            exwy_reg <= e_x * w_y;
            eywx_reg <= e_y * w_x;
            dxwy_reg <= d_x * w_y;
            dywx_reg <= d_y * w_x;
        end
    end

    always_comb begin
        det    = SW'(dxey_reg) - SW'(dyex_reg);
        num1   = SW'(exwy_reg) - SW'(eywx_reg);
        num2   = SW'(dxwy_reg) - SW'(dywx_reg);
        pos_ok = (num1 >= 0) && (num1 < det) && (num2 >= 0) && (num2 < det);
        neg_ok = (num1 <= 0) && (num1 > det) && (num2 <= 0) && (num2 > det);
        if (det > 0) begin
            hit = pos_ok;
        end else if (det < 0) begin
            hit = neg_ok;
        end else begin
            hit = 1'b0;
        end
    end

endmodule
